### hw/rtl/ascii_to_hid_keystroke_injector_unit_macros.svh
// ----------------------------------------------------------------------------
// a2h assertion macros
// shared property shorthands for the keystroke injector checker
// ----------------------------------------------------------------------------
`ifndef ASCII_TO_HID_KEYSTROKE_INJECTOR_UNIT_MACROS_SVH
`define ASCII_TO_HID_KEYSTROKE_INJECTOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define A2H_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define A2H_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/a2h_pkg.sv
// ----------------------------------------------------------------------------
// a2h_pkg
// types, codes and lookup tables for the ascii to hid keystroke injector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package a2h_pkg;

  localparam int RING_DEPTH    = 16;
  localparam int EXT_KEY_COUNT = 8;

  localparam int CODE_W  = 11;
  localparam int KEY_W   = 8;
  localparam int ENTRY_W = 9;
  localparam int STAT_W  = 2;
  localparam int MOD_W   = 2;

  localparam logic [CODE_W-1:0] EXT_BASE_RESET = 11'd1000;

  // opcodes
  localparam logic OP_INJECT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // inject status codes
  localparam logic [STAT_W-1:0] ST_QUEUED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOMAP  = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNSUP  = 2'd3;

  // modifier byte values
  localparam logic [MOD_W-1:0] MOD_NONE   = 2'd0;
  localparam logic [MOD_W-1:0] MOD_LSHIFT = 2'd2;

  // key sequencer phases (the unused code behaves as idle)
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DOWN = 2'd1;
  localparam logic [1:0] PH_UP   = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } a2h_cmd_t;

  // bit 8 shift, bits 7..0 usage code
  localparam logic [ENTRY_W-1:0] ASCII_ROM [0:127] = '{
    9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
    9'h02A, 9'h02B, 9'h028, 9'h000, 9'h000, 9'h028, 9'h000, 9'h000,
    9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
    9'h000, 9'h000, 9'h000, 9'h029, 9'h000, 9'h000, 9'h000, 9'h000,
    9'h02C, 9'h11E, 9'h134, 9'h120, 9'h121, 9'h122, 9'h124, 9'h034,
    9'h126, 9'h127, 9'h125, 9'h12E, 9'h036, 9'h02D, 9'h037, 9'h038,
    9'h027, 9'h01E, 9'h01F, 9'h020, 9'h021, 9'h022, 9'h023, 9'h024,
    9'h025, 9'h026, 9'h133, 9'h033, 9'h136, 9'h02E, 9'h137, 9'h138,
    9'h11F, 9'h104, 9'h105, 9'h106, 9'h107, 9'h108, 9'h109, 9'h10A,
    9'h10B, 9'h10C, 9'h10D, 9'h10E, 9'h10F, 9'h110, 9'h111, 9'h112,
    9'h113, 9'h114, 9'h115, 9'h116, 9'h117, 9'h118, 9'h119, 9'h11A,
    9'h11B, 9'h11C, 9'h11D, 9'h02F, 9'h031, 9'h030, 9'h123, 9'h12D,
    9'h035, 9'h004, 9'h005, 9'h006, 9'h007, 9'h008, 9'h009, 9'h00A,
    9'h00B, 9'h00C, 9'h00D, 9'h00E, 9'h00F, 9'h010, 9'h011, 9'h012,
    9'h013, 9'h014, 9'h015, 9'h016, 9'h017, 9'h018, 9'h019, 9'h01A,
    9'h01B, 9'h01C, 9'h01D, 9'h12F, 9'h131, 9'h130, 9'h135, 9'h04C
  };

  // up, down, right, left, home, end, page up, page down
  localparam logic [KEY_W-1:0] EXT_ROM [0:7] = '{
    8'h52, 8'h51, 8'h4F, 8'h50, 8'h4A, 8'h4D, 8'h4B, 8'h4E
  };

endpackage

### hw/rtl/a2h_if.sv
// ----------------------------------------------------------------------------
// a2h interfaces
// request, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface a2h_req_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [a2h_pkg::CODE_W-1:0]   char_code;

  modport source (output valid, output opcode, output char_code, input ready);
  modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

interface a2h_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [a2h_pkg::STAT_W-1:0]   inject_status;
  logic                         event_valid;
  logic                         pressed;
  logic [a2h_pkg::KEY_W-1:0]    usage_code;
  logic [a2h_pkg::MOD_W-1:0]    modifiers;

  modport source (output valid, output inject_status, output event_valid,
                  output pressed, output usage_code, output modifiers,
                  input ready);
  modport sink   (input valid, input inject_status, input event_valid,
                  input pressed, input usage_code, input modifiers,
                  output ready);
endinterface

interface a2h_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [a2h_pkg::CODE_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/a2h_ram.sv
// ----------------------------------------------------------------------------
// a2h_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module a2h_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/a2h_ctrl.sv
// ----------------------------------------------------------------------------
// a2h_ctrl
// item sequencer: accept, execute, then hold the result beat until taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module a2h_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output a2h_pkg::a2h_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // ring read data lands here
        cmd.execute = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/a2h_dpath.sv
// ----------------------------------------------------------------------------
// a2h_dpath
// keycode translation, key ring, key sequencer and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module a2h_dpath #(
  parameter int RING_DEPTH = a2h_pkg::RING_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  a2h_pkg::a2h_cmd_t           cmd,
  input  logic                        req_opcode,
  input  logic [a2h_pkg::CODE_W-1:0]  req_char_code,
  input  logic                        cfg_wr,
  input  logic [a2h_pkg::CODE_W-1:0]  cfg_data,
  output logic [a2h_pkg::STAT_W-1:0]  inject_status,
  output logic                        event_valid,
  output logic                        pressed,
  output logic [a2h_pkg::KEY_W-1:0]   usage_code,
  output logic [a2h_pkg::MOD_W-1:0]   modifiers
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

  logic [a2h_pkg::CODE_W-1:0]  ext_base;
  logic [IDX_W-1:0]            write_index;
  logic [IDX_W-1:0]            read_index;
  logic [1:0]                  phase;
  logic [a2h_pkg::KEY_W-1:0]   held_keycode;
  logic                        held_shift;

  logic [a2h_pkg::STAT_W-1:0]  status_q;
  logic                        down_q;
  logic                        up_q;

  logic [IDX_W-1:0]            wr_next;
  logic [IDX_W-1:0]            rd_next;
  logic                        full;
  logic                        nonempty;
  logic                        is_ascii;
  logic [a2h_pkg::ENTRY_W-1:0] ascii_entry;
  logic [a2h_pkg::CODE_W:0]    ext_diff;
  logic                        in_ext;
  logic [a2h_pkg::ENTRY_W-1:0] entry;
  logic [a2h_pkg::STAT_W-1:0]  status;
  logic                        is_tick;
  logic                        do_push;
  logic                        do_pop;
  logic                        do_up;
  logic [a2h_pkg::ENTRY_W-1:0] ring_rdata;
  logic                        out_shift;

  always_comb begin
    wr_next  = (write_index == IDX_LAST) ? '0 : write_index + 1'b1;
    rd_next  = (read_index == IDX_LAST) ? '0 : read_index + 1'b1;
    full     = (wr_next == read_index);
    nonempty = (read_index != write_index);

    is_ascii    = (req_char_code[a2h_pkg::CODE_W-1:7] == '0);
    ascii_entry = a2h_pkg::ASCII_ROM[req_char_code[6:0]];
    ext_diff    = {1'b0, req_char_code} - {1'b0, ext_base};
    in_ext      = !ext_diff[a2h_pkg::CODE_W] &&
                  (ext_diff < (a2h_pkg::CODE_W+1)'(a2h_pkg::EXT_KEY_COUNT));
    entry       = is_ascii ? ascii_entry
                           : {1'b0, a2h_pkg::EXT_ROM[ext_diff[2:0]]};

    // full check wins over translation
    priority if (full) begin
      status = a2h_pkg::ST_FULL;
    end else if (is_ascii || in_ext) begin
      status = (entry[a2h_pkg::KEY_W-1:0] == '0) ? a2h_pkg::ST_NOMAP
                                                 : a2h_pkg::ST_QUEUED;
    end else begin
      status = a2h_pkg::ST_UNSUP;
    end

    is_tick = (req_opcode == a2h_pkg::OP_TICK);
    do_push = cmd.capture && !is_tick && (status == a2h_pkg::ST_QUEUED);
    do_up   = cmd.capture && is_tick && (phase == a2h_pkg::PH_UP);
    do_pop  = cmd.capture && is_tick && (phase != a2h_pkg::PH_DOWN) &&
              (phase != a2h_pkg::PH_UP) && nonempty;
  end

  a2h_ram #(
    .WIDTH (a2h_pkg::ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (do_push),
    .waddr (write_index),
    .wdata (entry),
    .re    (do_pop),
    .raddr (read_index),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_base     <= a2h_pkg::EXT_BASE_RESET;
      write_index  <= '0;
      read_index   <= '0;
      phase        <= a2h_pkg::PH_IDLE;
      held_keycode <= '0;
      held_shift   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        ext_base <= cfg_data;
      end
      if (do_push) begin
        write_index <= wr_next;
      end
      if (do_pop) begin
        read_index <= rd_next;
      end
      if (cmd.capture && is_tick) begin
        if (phase == a2h_pkg::PH_DOWN) begin
          phase <= a2h_pkg::PH_UP;
        end else if (do_pop) begin
          phase <= a2h_pkg::PH_DOWN;
        end else begin
          phase <= a2h_pkg::PH_IDLE;
        end
      end
      if (cmd.execute && down_q) begin
        held_keycode <= ring_rdata[a2h_pkg::KEY_W-1:0];
        held_shift   <= ring_rdata[a2h_pkg::KEY_W];
      end
    end
  end

  // per-item flags, only read in the execute cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status_q <= is_tick ? a2h_pkg::ST_QUEUED : status;
      down_q   <= do_pop;
      up_q     <= do_up;
    end
  end

  assign out_shift = down_q ? ring_rdata[a2h_pkg::KEY_W] : (up_q && held_shift);

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      inject_status <= status_q;
      event_valid   <= down_q || up_q;
      pressed       <= down_q;
      if (down_q) begin
        usage_code <= ring_rdata[a2h_pkg::KEY_W-1:0];
      end else if (up_q) begin
        usage_code <= held_keycode;
      end else begin
        usage_code <= '0;
      end
      modifiers <= out_shift ? a2h_pkg::MOD_LSHIFT : a2h_pkg::MOD_NONE;
    end
  end

endmodule

### hw/rtl/ascii_to_hid_keystroke_injector_unit.sv
// a request beat is followed by the execute state, then the result beat,
// and no new request is accepted until that result beat is taken; the
// controller sequence (accept, execute, result beat) wraps the registered ring read
// reset: synchronous; pointers, key phase and held key cleared, base = 1000
// ring contents are not cleared, so the block is ready right after reset
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// ascii_to_hid_keystroke_injector_unit
// queues translated characters and plays them out as hid key down/up events
// ----------------------------------------------------------------------------
module ascii_to_hid_keystroke_injector_unit #(
  parameter int RING_DEPTH = a2h_pkg::RING_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  a2h_req_if.sink    req,
  a2h_rsp_if.source  rsp,
  a2h_cfg_if.sink    cfg
);

  a2h_pkg::a2h_cmd_t cmd;

  // base register may be written at any time the block is idle
  assign cfg.ready = 1'b1;

  a2h_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  a2h_dpath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_opcode    (req.opcode),
    .req_char_code (req.char_code),
    .cfg_wr        (cfg.valid && cfg.ready),
    .cfg_data      (cfg.data),
    .inject_status (rsp.inject_status),
    .event_valid   (rsp.event_valid),
    .pressed       (rsp.pressed),
    .usage_code    (rsp.usage_code),
    .modifiers     (rsp.modifiers)
  );

endmodule

### hw/rtl/a2h_checker.sv
// ----------------------------------------------------------------------------
// a2h_checker
// port-level checks on the keystroke injector, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ascii_to_hid_keystroke_injector_unit_macros.svh"

module a2h_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [a2h_pkg::STAT_W-1:0]  inject_status,
  input logic                        event_valid,
  input logic                        pressed,
  input logic [a2h_pkg::KEY_W-1:0]   usage_code,
  input logic [a2h_pkg::MOD_W-1:0]   modifiers
);

  logic pending;

  // one item in flight between request beat and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      pending <= 1'b0;
    end else if (req_valid && req_ready) begin
      pending <= 1'b1;
    end
  end

  `A2H_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid,
                  "result beat dropped")
  `A2H_ASSERT_IMP(a_no_overrun, pending, !(req_valid && req_ready),
                  "request taken in flight")
  `A2H_ASSERT_IMP(a_rsp_owned, rsp_valid, pending, "result without a request")
  `A2H_ASSERT_IMP(a_quiet_event, rsp_valid && !event_valid,
                  !pressed && usage_code == '0 && modifiers == a2h_pkg::MOD_NONE,
                  "fields set without event")
  `A2H_ASSERT_IMP(a_status_event, rsp_valid && inject_status != a2h_pkg::ST_QUEUED,
                  !event_valid, "event on rejected inject")

endmodule

bind ascii_to_hid_keystroke_injector_unit a2h_checker u_a2h_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .inject_status (rsp.inject_status),
  .event_valid   (rsp.event_valid),
  .pressed       (rsp.pressed),
  .usage_code    (rsp.usage_code),
  .modifiers     (rsp.modifiers)
);

### tb/tb_ascii_to_hid_keystroke_injector_unit.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_ascii_to_hid_keystroke_injector_unit
// drives inject requests and ticks through the request channel, predicts every
// response beat with an independent model of the ring queue and the key
// sequencer, and checks each beat in order; the navigation key base is moved
// between traffic phases while the block is idle
// ----------------------------------------------------------------------------
module tb_ascii_to_hid_keystroke_injector_unit;
  import a2h_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);

  typedef struct packed {
    logic             shift;
    logic [KEY_W-1:0] usage;
  } key_entry_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic              event_valid;
    logic              pressed;
    logic [KEY_W-1:0]  usage_code;
    logic [MOD_W-1:0]  modifiers;
  } keystroke_report_t;

  typedef struct {
    logic              opcode;
    logic [CODE_W-1:0] char_code;
  } inject_item_t;

  logic clk = 1'b0;
  logic rst;

  a2h_req_if req ();
  a2h_rsp_if rsp ();
  a2h_cfg_if cfg ();

  ascii_to_hid_keystroke_injector_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always #2 clk = ~clk;

  // shadow of the block state
  key_entry_t        key_ring [RING_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [1:0]        key_phase;
  key_entry_t        held_key;
  logic [CODE_W-1:0] nav_base;

  inject_item_t      item_q [$];
  keystroke_report_t keystroke_q [$];

  int mismatch_cnt = 0;

  // us layout, bit 8 set where the character needs left shift
  function automatic key_entry_t ascii_usage(input logic [6:0] c);
    key_entry_t e;
    e = '0;
    if (c >= 7'd97 && c <= 7'd122) begin
      e = {1'b0, 8'(8'h04 + (c - 7'd97))};
    end else if (c >= 7'd65 && c <= 7'd90) begin
      e = {1'b1, 8'(8'h04 + (c - 7'd65))};
    end else if (c >= 7'd49 && c <= 7'd57) begin
      e = {1'b0, 8'(8'h1E + (c - 7'd49))};
    end else begin
      case (c)
        7'd8:   e = {1'b0, 8'h2A};  // backspace
        7'd9:   e = {1'b0, 8'h2B};  // tab
        7'd10:  e = {1'b0, 8'h28};  // line feed -> enter
        7'd13:  e = {1'b0, 8'h28};  // carriage return -> enter
        7'd27:  e = {1'b0, 8'h29};  // escape
        7'd32:  e = {1'b0, 8'h2C};
        7'd33:  e = {1'b1, 8'h1E};
        7'd34:  e = {1'b1, 8'h34};
        7'd35:  e = {1'b1, 8'h20};
        7'd36:  e = {1'b1, 8'h21};
        7'd37:  e = {1'b1, 8'h22};
        7'd38:  e = {1'b1, 8'h24};
        7'd39:  e = {1'b0, 8'h34};
        7'd40:  e = {1'b1, 8'h26};
        7'd41:  e = {1'b1, 8'h27};
        7'd42:  e = {1'b1, 8'h25};
        7'd43:  e = {1'b1, 8'h2E};
        7'd44:  e = {1'b0, 8'h36};
        7'd45:  e = {1'b0, 8'h2D};
        7'd46:  e = {1'b0, 8'h37};
        7'd47:  e = {1'b0, 8'h38};
        7'd48:  e = {1'b0, 8'h27};
        7'd58:  e = {1'b1, 8'h33};
        7'd59:  e = {1'b0, 8'h33};
        7'd60:  e = {1'b1, 8'h36};
        7'd61:  e = {1'b0, 8'h2E};
        7'd62:  e = {1'b1, 8'h37};
        7'd63:  e = {1'b1, 8'h38};
        7'd64:  e = {1'b1, 8'h1F};
        7'd91:  e = {1'b0, 8'h2F};
        7'd92:  e = {1'b0, 8'h31};
        7'd93:  e = {1'b0, 8'h30};
        7'd94:  e = {1'b1, 8'h23};
        7'd95:  e = {1'b1, 8'h2D};
        7'd96:  e = {1'b0, 8'h35};
        7'd123: e = {1'b1, 8'h2F};
        7'd124: e = {1'b1, 8'h31};
        7'd125: e = {1'b1, 8'h30};
        7'd126: e = {1'b1, 8'h35};
        7'd127: e = {1'b0, 8'h4C};  // delete
        default: e = '0;
      endcase
    end
    return e;
  endfunction

  // up, down, right, left, home, end, page up, page down
  function automatic logic [KEY_W-1:0] nav_usage(input logic [2:0] idx);
    case (idx)
      3'd0: return 8'h52;
      3'd1: return 8'h51;
      3'd2: return 8'h4F;
      3'd3: return 8'h50;
      3'd4: return 8'h4A;
      3'd5: return 8'h4D;
      3'd6: return 8'h4B;
      default: return 8'h4E;
    endcase
  endfunction

  function automatic keystroke_report_t predict_keystroke(input logic op,
                                                          input logic [CODE_W-1:0] code);
    keystroke_report_t r;
    key_entry_t        e;
    logic [PTR_W-1:0]  nxt;
    logic [CODE_W:0]   offs;
    r = '{status: ST_QUEUED, event_valid: 1'b0, pressed: 1'b0,
          usage_code: '0, modifiers: MOD_NONE};
    if (op == OP_INJECT) begin
      nxt  = wr_ptr + 1'b1;
      offs = {1'b0, code} - {1'b0, nav_base};
      if (nxt == rd_ptr) begin
        r.status = ST_FULL;
      end else if (code <= 11'd127) begin
        e = ascii_usage(code[6:0]);
        if (e.usage == '0) begin
          r.status = ST_NOMAP;
        end else begin
          key_ring[wr_ptr] = e;
          wr_ptr = nxt;
        end
      end else if (code >= nav_base && offs < 12'd8) begin
        key_ring[wr_ptr] = {1'b0, nav_usage(offs[2:0])};
        wr_ptr = nxt;
      end else begin
        r.status = ST_UNSUP;
      end
    end else begin
      case (key_phase)
        PH_DOWN: key_phase = PH_UP;
        PH_UP: begin
          r.event_valid = 1'b1;
          r.usage_code  = held_key.usage;
          r.modifiers   = held_key.shift ? MOD_LSHIFT : MOD_NONE;
          key_phase     = PH_IDLE;
        end
        default: begin
          key_phase = PH_IDLE;
          if (rd_ptr != wr_ptr) begin
            held_key      = key_ring[rd_ptr];
            rd_ptr        = rd_ptr + 1'b1;
            r.event_valid = 1'b1;
            r.pressed     = 1'b1;
            r.usage_code  = held_key.usage;
            r.modifiers   = held_key.shift ? MOD_LSHIFT : MOD_NONE;
            key_phase     = PH_DOWN;
          end
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- sender
  int           burst_left = 1;
  int           gap_left   = 0;
  inject_item_t drv_item;

  always @(posedge clk) begin
    if (rst) begin
      req.valid     <= 1'b0;
      req.opcode    <= OP_INJECT;
      req.char_code <= '0;
    end else begin
      if (req.valid && req.ready) begin
        keystroke_q.push_back(predict_keystroke(req.opcode, req.char_code));
      end
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left  = gap_left - 1;
          req.valid <= 1'b0;
        end else if (item_q.size() != 0) begin
          drv_item       = item_q.pop_front();
          req.valid     <= 1'b1;
          req.opcode    <= drv_item.opcode;
          req.char_code <= drv_item.char_code;
          burst_left     = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------- receiver
  int                rsp_beats   = 0;
  int                hold_left   = 0;
  int                mode_left   = 0;
  int                stall_mode  = 0;
  int                stall_cyc   = 0;
  logic              ready_nxt;
  keystroke_report_t exp_rsp;

  task automatic flag_mismatch(input string msg);
    if (mismatch_cnt < 10) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp_beats++;
        if (keystroke_q.size() == 0) begin
          flag_mismatch("response beat with nothing expected");
        end else begin
          exp_rsp = keystroke_q.pop_front();
          if (rsp.inject_status !== exp_rsp.status ||
              rsp.event_valid !== exp_rsp.event_valid ||
              rsp.pressed !== exp_rsp.pressed ||
              rsp.usage_code !== exp_rsp.usage_code ||
              rsp.modifiers !== exp_rsp.modifiers) begin
            flag_mismatch($sformatf(
              {"beat %0d exp st=%0d ev=%0d dn=%0d key=%02h mod=%0d",
               " got st=%0d ev=%0d dn=%0d key=%02h mod=%0d"},
              rsp_beats, exp_rsp.status, exp_rsp.event_valid, exp_rsp.pressed,
              exp_rsp.usage_code, exp_rsp.modifiers, rsp.inject_status, rsp.event_valid,
              rsp.pressed, rsp.usage_code, rsp.modifiers));
          end
        end
        // long back-pressure so the block backs up into the request channel
        if (rsp_beats == 400 || rsp_beats == 1300) hold_left = 300;
      end
      stall_cyc++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = 64;
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_nxt = 1'b0;
      end else begin
        case (stall_mode)
          0: ready_nxt = 1'b1;
          1: ready_nxt = ($urandom_range(0, 3) != 0);
          2: ready_nxt = ($urandom_range(0, 3) == 0);
          default: ready_nxt = stall_cyc[2];
        endcase
      end
      rsp.ready <= ready_nxt;
    end
  end

  // -------------------------------------------------------------- stimulus
  function automatic logic [CODE_W-1:0] pick_code(input bit keys_only);
    int sel;
    sel = $urandom_range(0, 9);
    if (keys_only) begin
      if (sel < 7) return CODE_W'($urandom_range(32, 126));
      return nav_base + CODE_W'($urandom_range(0, 7));
    end
    case (sel)
      0, 1, 2, 3: return CODE_W'($urandom_range(0, 127));
      4, 5:       return nav_base + CODE_W'($urandom_range(0, 7));
      6: begin
        if ($urandom_range(0, 1) == 0) return nav_base - 1'b1;
        return (nav_base > 11'd2039) ? 11'd127 : nav_base + 11'd8;
      end
      default:    return CODE_W'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic push_item(input logic op, input logic [CODE_W-1:0] code);
    inject_item_t it;
    it.opcode    = op;
    it.char_code = code;
    item_q.push_back(it);
  endtask

  task automatic queue_traffic(input int n, input bit open_with_fill);
    int cnt;
    int seg;
    int k;
    cnt = 0;
    while (cnt < n) begin
      seg = open_with_fill ? 0 : $urandom_range(0, 9);
      open_with_fill = 1'b0;
      if (seg < 3) begin
        // typed string of 12 to 18 keys, which can run into a full ring
        k = $urandom_range(12, 18);
        repeat (k) push_item(OP_INJECT, pick_code(1'b1));
      end else if (seg < 6) begin
        k = 3 * $urandom_range(1, 8) + $urandom_range(0, 2);
        repeat (k) push_item(OP_TICK, CODE_W'($urandom_range(0, 2047)));
      end else if (seg < 9) begin
        k = $urandom_range(20, 40);
        repeat (k) begin
          if ($urandom_range(0, 1) == 0) push_item(OP_INJECT, pick_code(1'b0));
          else push_item(OP_TICK, CODE_W'($urandom_range(0, 2047)));
        end
      end else begin
        k = $urandom_range(5, 15);
        repeat (k) push_item(OP_INJECT, CODE_W'($urandom_range(0, 2047)));
      end
      cnt += k;
    end
  endtask

  task automatic wait_idle();
    while (item_q.size() != 0 || req.valid || keystroke_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_nav_base(input logic [CODE_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    nav_base = value;
    cfg.valid <= 1'b0;
  endtask

  logic [CODE_W-1:0] base_plan [6];

  initial begin
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.opcode    = OP_INJECT;
    req.char_code = '0;
    rsp.ready     = 1'b0;
    cfg.valid     = 1'b0;
    cfg.data      = '0;
    wr_ptr        = '0;
    rd_ptr        = '0;
    key_phase     = PH_IDLE;
    held_key      = '0;
    nav_base      = EXT_BASE_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_nav_base(11'd128);
    @(negedge clk);
    push_item(OP_TICK, 11'h7FF);      // idle with nothing queued
    push_item(OP_INJECT, 11'd0);      // no mapping
    push_item(OP_INJECT, 11'd127);
    push_item(OP_INJECT, 11'd65);     // shifted letter
    push_item(OP_INJECT, 11'd128);    // first navigation key
    push_item(OP_INJECT, 11'd135);    // last navigation key
    push_item(OP_INJECT, 11'd136);    // just past the navigation range
    push_item(OP_INJECT, 11'd2047);
    push_item(OP_TICK, 11'd0);        // key down
    push_item(OP_INJECT, 11'd32);     // request while a key is held
    push_item(OP_TICK, 11'd0);
    push_item(OP_TICK, 11'd0);        // key up
    repeat (13) push_item(OP_TICK, 11'h555);
    wait_idle();

    base_plan = '{11'd2040, EXT_BASE_RESET, CODE_W'($urandom_range(128, 2040)),
                  11'd128, CODE_W'($urandom_range(128, 2040)),
                  CODE_W'($urandom_range(128, 2040))};
    foreach (base_plan[i]) begin
      write_nav_base(base_plan[i]);
      @(negedge clk);
      queue_traffic(325, i == 0);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && keystroke_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/a2h_pkg.sv
hw/rtl/a2h_if.sv
hw/rtl/a2h_ram.sv
hw/rtl/a2h_ctrl.sv
hw/rtl/a2h_dpath.sv
hw/rtl/ascii_to_hid_keystroke_injector_unit.sv
hw/rtl/a2h_checker.sv
tb/tb_ascii_to_hid_keystroke_injector_unit.sv
